/* rtl/core/hep_pkg.sv */
// Shared constants and types for the Huffman encoder and bit packer.
`timescale 1ns / 1ps
`default_nettype none

package hep_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 31;

    localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int SYM_W   = 8;
    localparam int LEN_W   = 5;
    localparam int CODE_W  = 31;
    localparam int ENTRY_W = CODE_W + LEN_W;
    localparam int BYTE_W  = 8;
    localparam int PART_W  = BYTE_W - 1;
    localparam int CNT_W   = 3;
    localparam int ACC_W   = PART_W + CODE_W;
    localparam int N_W     = 6;
    localparam int OUT_MAX = 4;
    localparam int OCNT_W  = 3;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/hep_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module hep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/huffman_encoder_bit_packer_core.sv */
// Top level of the Huffman symbol encoder with an MSB-first bit packer.
// The first byte of an encode or flush passes the table read and lookup stage register,
// then the output buffer register; a busy output buffer holds the item in the lookup stage.
// Throughput: one input transaction per cycle while the output buffer can take the staged item;
// an item that yields k bytes sends them one at a time on the one-byte output port, up to four per symbol.
// Reset clears the pipeline, the output buffer and the pending bits; the code table
// is undefined until each entry is loaded and has no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module huffman_encoder_bit_packer_core
    import hep_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // symbol[7:0], code_length[12:8], code_bits[43:13], zero pad
    input  wire logic [1:0]  s_tuser,  // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // out_byte[7:0]
    output logic             m_tlast
);

    typedef struct packed {
        logic valid;
        cmd_t cmd;
        logic sym_ok;
    } stage_t;

    logic [SYM_W-1:0]  in_sym;
    logic [LEN_W-1:0]  in_len;
    logic [CODE_W-1:0] in_code;
    cmd_t              in_cmd;
    logic              in_sym_ok;
    logic              s_accept;
    logic [LEN_W-1:0]  sat_len;
    logic [CODE_W-1:0] masked_code;

    logic              ram_we;
    logic              ram_re;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [LEN_W-1:0]  rd_len;
    logic [CODE_W-1:0] rd_code;

    stage_t            st_reg;
    stage_t            st_next;
    logic              st_fire;
    logic              buf_free;

    logic [PART_W-1:0] pbits_reg;
    logic [PART_W-1:0] pbits_next;
    logic [CNT_W-1:0]  pcnt_reg;
    logic [CNT_W-1:0]  pcnt_next;

    logic [BYTE_W-1:0] obuf_reg [OUT_MAX];
    logic [BYTE_W-1:0] obuf_next [OUT_MAX];
    logic [OCNT_W-1:0] ocnt_reg;
    logic [OCNT_W-1:0] ocnt_next;
    logic              m_accept;

    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  top;
    logic [N_W-1:0]    nbits;
    logic [BYTE_W-1:0] flush_byte;

    assign in_sym    = s_tdata[SYM_W-1:0];
    assign in_len    = s_tdata[SYM_W+LEN_W-1:SYM_W];
    assign in_code   = s_tdata[SYM_W+LEN_W+CODE_W-1:SYM_W+LEN_W];
    assign in_cmd    = cmd_t'(s_tuser);
    assign in_sym_ok = ((SYM_W + 1)'(in_sym) < (SYM_W + 1)'(SYMBOL_COUNT));
    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_tvalid && m_tready;

    assign sat_len     = (in_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : in_len;
    assign masked_code = in_code & CODE_W'((32'd1 << sat_len) - 32'd1);

    assign ram_we    = s_accept && (in_cmd == CMD_LOAD) && in_sym_ok;
    assign ram_re    = s_accept && (in_cmd == CMD_ENCODE);
    assign ram_wdata = {sat_len, masked_code};
    assign rd_code   = ram_rdata[CODE_W-1:0];
    assign rd_len    = ram_rdata[ENTRY_W-1:CODE_W];

    hep_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SYMBOL_COUNT)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(in_sym[ADDR_W-1:0]),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(in_sym[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    assign buf_free = (ocnt_reg == '0) || ((ocnt_reg == OCNT_W'(1)) && m_tready);
    assign st_fire  = st_reg.valid && buf_free;
    assign s_tready = !st_reg.valid || buf_free;

    always_comb
    begin
        st_next = st_reg;
        if (s_accept)
        begin
            st_next.valid  = (in_cmd == CMD_ENCODE) || (in_cmd == CMD_FLUSH);
            st_next.cmd    = in_cmd;
            st_next.sym_ok = in_sym_ok;
        end
        else if (st_fire)
        begin
            st_next.valid = 1'b0;
        end
    end

    assign acc        = (ACC_W'(pbits_reg) << rd_len) | ACC_W'(rd_code);
    assign nbits      = N_W'(pcnt_reg) + N_W'(rd_len);
    assign top        = acc << (N_W'(ACC_W) - nbits);
    assign flush_byte = BYTE_W'({1'b0, pbits_reg} << (4'd8 - {1'b0, pcnt_reg}));

    always_comb
    begin
        pbits_next = pbits_reg;
        pcnt_next  = pcnt_reg;
        ocnt_next  = ocnt_reg;
        for (int k = 0; k < OUT_MAX; k++)
        begin
            obuf_next[k] = obuf_reg[k];
        end
        if (m_accept)
        begin
            for (int k = 0; k < OUT_MAX - 1; k++)
            begin
                obuf_next[k] = obuf_reg[k+1];
            end
            ocnt_next = ocnt_reg - OCNT_W'(1);
        end
        if (st_fire)
        begin
            unique case (st_reg.cmd)
                CMD_ENCODE:
                begin
                    if (st_reg.sym_ok && (rd_len != '0))
                    begin
                        for (int k = 0; k < OUT_MAX; k++)
                        begin
                            obuf_next[k] = top[ACC_W-1-BYTE_W*k -: BYTE_W];
                        end
                        ocnt_next  = OCNT_W'(nbits[N_W-1:3]);
                        pcnt_next  = nbits[CNT_W-1:0];
                        pbits_next = acc[PART_W-1:0]
                                   & ((PART_W'(1) << nbits[CNT_W-1:0]) - PART_W'(1));
                    end
                    else
                    begin
                        ocnt_next = '0;
                    end
                end
                CMD_FLUSH:
                begin
                    if (pcnt_reg != '0)
                    begin
                        obuf_next[0] = flush_byte;
                        ocnt_next    = OCNT_W'(1);
                        pbits_next   = '0;
                        pcnt_next    = '0;
                    end
                    else
                    begin
                        ocnt_next = '0;
                    end
                end
                default:
                begin
                    ocnt_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= '{valid: 1'b0, cmd: CMD_LOAD, sym_ok: 1'b0};
            pbits_reg <= '0;
            pcnt_reg  <= '0;
            ocnt_reg  <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            pbits_reg <= pbits_next;
            pcnt_reg  <= pcnt_next;
            ocnt_reg  <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < OUT_MAX; k++)
        begin
            obuf_reg[k] <= obuf_next[k];
        end
    end

    assign m_tvalid = (ocnt_reg != '0);
    assign m_tdata  = obuf_reg[0];
    assign m_tlast  = (ocnt_reg == OCNT_W'(1));

    a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= OCNT_W'(OUT_MAX))
        else $error("Output buffer count exceeds four bytes.");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.valid && !buf_free) |=> (st_reg.valid && $stable(st_reg.cmd)
                                          && $stable(st_reg.sym_ok)))
        else $error("Stalled item left the lookup stage.");

    a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (st_fire && (st_reg.cmd == CMD_FLUSH) && (pcnt_reg != '0))
        |=> ((pcnt_reg == '0) && (ocnt_reg == OCNT_W'(1))))
        else $error("Flush did not emit one byte and clear the pending bits.");

endmodule

`default_nettype wire

/* tb/sv/huffman_encoder_bit_packer_core_tb.sv */
// Self-checking testbench for the Huffman encoder and MSB-first bit packer core.
`timescale 1ns / 1ps

module huffman_encoder_bit_packer_core_tb;
    import hep_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int RANDOM_ITEMS = 135;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  symbol;
        logic [4:0]  code_length;
        logic [30:0] code_bits;
    } coder_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } packed_byte_t;

    typedef struct {
        coder_item_t item;
        bit          typed;
        int          n_typed;
        logic [31:0] typed_bytes;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    logic [30:0]  code_table [SYMBOL_COUNT];
    logic [4:0]   length_table [SYMBOL_COUNT];
    bit           entry_loaded [SYMBOL_COUNT];
    logic [7:0]   loaded_symbols [$];
    logic [6:0]   pending_bits;
    logic [2:0]   pending_count;
    packed_byte_t predicted_bytes [$];
    packed_byte_t expected_bytes [$];
    stim_row_t    directed_rows [$];
    int           error_count;
    int           stall_cycles;
    bit           hold_off_req;

    huffman_encoder_bit_packer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Appends an accepted item's bytes to predicted_bytes; loads fill the table.
    function automatic void predict_packing(coder_item_t it);
        logic [4:0]  len;
        logic [63:0] mask;
        logic [63:0] acc;
        logic [7:0]  padded;
        int          n;
        case (it.command)
            CMD_LOAD:
            begin
                code_table[it.symbol] = it.code_bits;
                length_table[it.symbol] = it.code_length;
                if (!entry_loaded[it.symbol])
                begin
                    entry_loaded[it.symbol] = 1'b1;
                    loaded_symbols.insert(loaded_symbols.size(), it.symbol);
                end
            end
            CMD_ENCODE:
            begin
                len = length_table[it.symbol];
                if (len != 5'd0)
                begin
                    mask = (64'd1 << len) - 64'd1;
                    acc = (64'(pending_bits) << len) | (64'(code_table[it.symbol]) & mask);
                    n = int'(pending_count) + int'(len);
                    while (n >= 8)
                    begin
                        predicted_bytes.insert(predicted_bytes.size(),
                                               packed_byte_t'({8'(acc >> (n - 8)), (n - 8) < 8}));
                        n = n - 8;
                    end
                    pending_count = 3'(n);
                    pending_bits = 7'(acc & ((64'd1 << n) - 64'd1));
                end
            end
            CMD_FLUSH:
            begin
                if (pending_count != 3'd0)
                begin
                    padded = {1'b0, pending_bits} << (4'd8 - {1'b0, pending_count});
                    predicted_bytes.insert(predicted_bytes.size(),
                                           packed_byte_t'({padded, 1'b1}));
                    pending_bits = '0;
                    pending_count = '0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void add_row(logic [1:0] command, logic [7:0] symbol,
                                    logic [4:0] code_length, logic [30:0] code_bits,
                                    bit typed, int n_typed, logic [31:0] typed_bytes);
        stim_row_t row;
        row.item = '{command, symbol, code_length, code_bits};
        row.typed = typed;
        row.n_typed = n_typed;
        row.typed_bytes = typed_bytes;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    task automatic send_item(coder_item_t it, bit typed, int n_typed, logic [31:0] typed_bytes);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = it.command;
        s_tdata = {4'b0, it.code_bits, it.code_length, it.symbol};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_packing(it);
        if (typed)
        begin
            predicted_bytes.delete();
            for (int i = 0; i < n_typed; i++)
                expected_bytes.insert(expected_bytes.size(),
                                      packed_byte_t'({typed_bytes[31 - 8 * i -: 8],
                                                      i == n_typed - 1}));
        end
        else
        begin
            while (predicted_bytes.size() != 0)
                expected_bytes.insert(expected_bytes.size(), predicted_bytes.pop_front());
        end
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    function automatic coder_item_t random_item();
        coder_item_t it;
        int          pick;
        int          len_pick;
        it.symbol = 8'($urandom_range(0, 255));
        it.code_length = 5'($urandom_range(0, 31));
        it.code_bits = 31'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            it.command = CMD_LOAD;
            if ($urandom_range(0, 1) == 0)
                it.symbol = 8'($urandom_range(0, 15));
            len_pick = $urandom_range(0, 9);
            if (len_pick == 0)
                it.code_length = 5'd0;
            else if (len_pick == 1)
                it.code_length = 5'd31;
            else if (len_pick == 2)
                it.code_length = 5'($urandom_range(20, 30));
            else
                it.code_length = 5'($urandom_range(1, 12));
        end
        else if (pick < 20)
            it.command = CMD_UNKNOWN;
        else if (pick < 30)
            it.command = CMD_FLUSH;
        else
        begin
            it.command = CMD_ENCODE;
            it.symbol = loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)];
        end
        return it;
    endfunction

    always @(posedge clk)
    begin
        packed_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected output transaction: expected none, actual byte %h last %b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.out_byte)
                begin
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, want.out_byte, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL huffman_encoder_bit_packer_core");
            $finish;
        end
    end

    // The receiver is always ready, mostly ready, mostly stalled, or held off.
    initial
    begin
        int ready_mode;
        int mode_left;
        ready_mode = 0;
        mode_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (mode_left <= 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (ready_mode == 0)
                m_tready = 1'b1;
            else if (ready_mode == 1)
                m_tready = ($urandom_range(0, 3) != 0);
            else
                m_tready = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        coder_item_t it;
        int          sent;
        int          burst_left;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        error_count = 0;
        hold_off_req = 1'b0;
        pending_bits = '0;
        pending_count = '0;
        for (int i = 0; i < SYMBOL_COUNT; i++)
            entry_loaded[i] = 1'b0;

        add_row(CMD_FLUSH,   8'd0,   5'd0,  31'd0,          1, 0, 32'h0);
        add_row(CMD_UNKNOWN, 8'd255, 5'd31, 31'h7FFF_FFFF,  1, 0, 32'h0);
        add_row(CMD_LOAD,    8'd0,   5'd8,  31'h0000_00A5,  1, 0, 32'h0);
        add_row(CMD_ENCODE,  8'd0,   5'd0,  31'd0,          1, 1, 32'hA500_0000);
        add_row(CMD_LOAD,    8'd255, 5'd31, 31'h7FFF_FFFF,  1, 0, 32'h0);
        add_row(CMD_ENCODE,  8'd255, 5'd0,  31'd0,          1, 3, 32'hFFFF_FF00);
        add_row(CMD_FLUSH,   8'd0,   5'd0,  31'd0,          1, 1, 32'hFE00_0000);
        add_row(CMD_LOAD,    8'd1,   5'd0,  31'h7FFF_FFFF,  1, 0, 32'h0);
        add_row(CMD_ENCODE,  8'd1,   5'd31, 31'h7FFF_FFFF,  1, 0, 32'h0);
        add_row(CMD_LOAD,    8'd2,   5'd3,  31'h7FFF_FFFD,  1, 0, 32'h0);
        add_row(CMD_ENCODE,  8'd2,   5'd0,  31'd0,          1, 0, 32'h0);
        add_row(CMD_FLUSH,   8'd0,   5'd0,  31'd0,          1, 1, 32'hA000_0000);
        add_row(CMD_LOAD,    8'd128, 5'd31, 31'd0,          1, 0, 32'h0);
        add_row(CMD_LOAD,    8'd3,   5'd1,  31'd1,          1, 0, 32'h0);
        add_row(CMD_ENCODE,  8'd3,   5'd0,  31'd0,          0, 0, 32'h0);
        add_row(CMD_ENCODE,  8'd128, 5'd0,  31'd0,          0, 0, 32'h0);
        add_row(CMD_ENCODE,  8'd2,   5'd0,  31'd0,          0, 0, 32'h0);
        add_row(CMD_ENCODE,  8'd255, 5'd0,  31'd0,          0, 0, 32'h0);
        add_row(CMD_UNKNOWN, 8'd0,   5'd0,  31'd0,          0, 0, 32'h0);
        add_row(CMD_FLUSH,   8'd0,   5'd0,  31'd0,          0, 0, 32'h0);
        add_row(CMD_LOAD,    8'd0,   5'd5,  31'h0000_0015,  0, 0, 32'h0);
        add_row(CMD_ENCODE,  8'd0,   5'd0,  31'd0,          0, 0, 32'h0);
        add_row(CMD_ENCODE,  8'd0,   5'd0,  31'd0,          0, 0, 32'h0);
        add_row(CMD_ENCODE,  8'd3,   5'd0,  31'd0,          0, 0, 32'h0);
        add_row(CMD_FLUSH,   8'd0,   5'd0,  31'd0,          0, 0, 32'h0);

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].n_typed, directed_rows[i].typed_bytes);

        sent = 0;
        burst_left = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 9) >= 3)
                    pause_sender($urandom_range(1, 8));
                burst_left = $urandom_range(1, 16);
            end
            if (sent == 40)
                hold_off_req = 1'b1;
            it = random_item();
            send_item(it, 1'b0, 0, 32'h0);
            burst_left--;
            sent++;
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (error_count == 0 && expected_bytes.size() == 0)
            $display("PASS huffman_encoder_bit_packer_core");
        else
            $display("FAIL huffman_encoder_bit_packer_core");
        $finish;
    end

endmodule
